FILE: src/tiop_pkg.sv
// Package for the typed interval overlap search unit.
// Holds the operation, type and status codes and the structs that pass between
// the top level and the cell chain. It depends on nothing.
package tiop_pkg;

    localparam int CHROM_W       = 8;
    localparam int COORD_W       = 31;
    localparam int SUM_W         = 32;
    localparam int KIND_W        = 2;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_INDEX_W = 10;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_DEL   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INS   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INV   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd3;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_HIT      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISS     = 2'd3;

    // Query held steady at every cell while a scan runs.
    typedef struct packed {
        logic [CHROM_W-1:0] chrom;
        logic [COORD_W-1:0] pos;
        logic [SUM_W-1:0]   qend;
    } query_t;

    // Entry write broadcast to every cell; the cell at the fill count takes it.
    typedef struct packed {
        logic               en;
        logic [CHROM_W-1:0] chrom;
        logic [COORD_W-1:0] begin_pos;
        logic [COORD_W-1:0] length;
        logic [KIND_W-1:0]  kind;
    } entry_wr_t;

    // Search packet handed from cell to cell.
    typedef struct packed {
        logic               found;
        logic [COORD_W-1:0] begin_pos;
        logic [COORD_W-1:0] length;
        logic [KIND_W-1:0]  kind;
    } packet_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [ENTRY_INDEX_W-1:0] entry_index;
        logic [COORD_W-1:0]       hit_begin;
        logic [COORD_W-1:0]       hit_length;
        logic [KIND_W-1:0]        hit_type;
    } result_t;

endpackage

FILE: src/tiop_req_if.sv
// Request channel of the typed interval overlap search unit.
// Carries valid, ready and one insert or query item; no dependencies.
interface tiop_req_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [7:0]         chrom_id;
    logic [30:0]        track_begin;
    logic [30:0]        track_end;
    logic [1:0]         track_type;
    logic signed [31:0] length_value;
    logic [30:0]        query_position;
    logic [30:0]        query_length;

    modport source (
        output valid, opcode, chrom_id, track_begin, track_end, track_type,
               length_value, query_position, query_length,
        input  ready
    );

    modport sink (
        input  valid, opcode, chrom_id, track_begin, track_end, track_type,
               length_value, query_position, query_length,
        output ready
    );
endinterface

FILE: src/tiop_rsp_if.sv
// Response channel of the typed interval overlap search unit.
// Carries valid, ready and one result item; no dependencies.
interface tiop_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [9:0]  entry_index;
    logic [30:0] hit_begin;
    logic [30:0] hit_length;
    logic [1:0]  hit_type;

    modport source (
        output valid, status, entry_index, hit_begin, hit_length, hit_type,
        input  ready
    );

    modport sink (
        input  valid, status, entry_index, hit_begin, hit_length, hit_type,
        output ready
    );
endinterface

FILE: src/tiop_cell.sv
// One cell of the search chain: stores one table entry and tests it against
// the broadcast query as the search packet passes. Depends on tiop_pkg.
module tiop_cell
    import tiop_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int IDX_W = 10,
    parameter int CNT_W = 11
) (
    input  logic             clk,
    input  query_t           query,
    input  logic [CNT_W-1:0] count,
    input  entry_wr_t        wr,
    input  packet_t          pkt_in,
    input  logic [IDX_W-1:0] idx_in,
    output packet_t          pkt_out,
    output logic [IDX_W-1:0] idx_out
);

    logic [CHROM_W-1:0] chrom_reg;
    logic [COORD_W-1:0] begin_reg;
    logic [COORD_W-1:0] length_reg;
    logic [KIND_W-1:0]  kind_reg;
    packet_t            pkt_reg;
    packet_t            pkt_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic [SUM_W-1:0]   entry_end;
    logic [SUM_W-1:0]   pos_ext;
    logic [SUM_W-1:0]   begin_ext;
    logic               in_range;
    logic               kind_match;
    logic               hit;

    // The entry is taken while the fill count points at this cell.
    always_ff @(posedge clk)
    begin
        if (wr.en && (count == CNT_W'(IDX)))
        begin
            chrom_reg  <= wr.chrom;
            begin_reg  <= wr.begin_pos;
            length_reg <= wr.length;
            kind_reg   <= wr.kind;
        end
    end

    always_comb
    begin
        begin_ext = {1'b0, begin_reg};
        pos_ext   = {1'b0, query.pos};
        entry_end = begin_ext + {1'b0, length_reg};
        in_range  = count > CNT_W'(IDX);
        case (kind_reg) inside
            KIND_DEL:
                kind_match = (pos_ext <= begin_ext) && (query.qend > begin_ext);
            KIND_INS, KIND_INV:
                kind_match = (pos_ext <= entry_end) && (query.qend >= begin_ext);
            default:
                kind_match = 1'b0;
        endcase
        hit = !pkt_in.found && in_range && (chrom_reg == query.chrom) && kind_match;
        if (hit)
        begin
            pkt_next.found     = 1'b1;
            pkt_next.begin_pos = begin_reg;
            pkt_next.length    = length_reg;
            pkt_next.kind      = kind_reg;
            idx_next           = IDX_W'(IDX);
        end
        else
        begin
            pkt_next = pkt_in;
            idx_next = idx_in;
        end
    end

    always_ff @(posedge clk)
    begin
        pkt_reg <= pkt_next;
        idx_reg <= idx_next;
    end

    assign pkt_out = pkt_reg;
    assign idx_out = idx_reg;

endmodule

FILE: src/tiop_chain.sv
// Row of search cells, one per table entry, with the packet handed down the row.
// A fresh empty packet enters the first cell every cycle. Depends on tiop_pkg, tiop_cell.
module tiop_chain
    import tiop_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int IDX_W = 10,
    parameter int CNT_W = 11
) (
    input  logic             clk,
    input  query_t           query,
    input  logic [CNT_W-1:0] count,
    input  entry_wr_t        wr,
    output packet_t          pkt_tail,
    output logic [IDX_W-1:0] idx_tail
);

    packet_t          pkt [0:DEPTH];
    logic [IDX_W-1:0] idx [0:DEPTH];

    assign pkt[0] = '0;
    assign idx[0] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        tiop_cell #(
            .IDX   (i),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk     (clk),
            .query   (query),
            .count   (count),
            .wr      (wr),
            .pkt_in  (pkt[i]),
            .idx_in  (idx[i]),
            .pkt_out (pkt[i+1]),
            .idx_out (idx[i+1])
        );
    end

    assign pkt_tail = pkt[DEPTH];
    assign idx_tail = idx[DEPTH];

endmodule

FILE: src/typed_interval_overlap_search_unit.sv
// Typed interval overlap search unit.
// The req channel takes one item at a time: an insert appends an entry
// (chromosome, begin, stored length, type) at the fill count, a query asks for
// the first stored entry, in insertion order, on the same chromosome that
// overlaps the queried region. Each item gives one result item on rsp.
// The table is a row of TABLE_DEPTH cells, one per entry. A query sends a
// search packet down the row, one cell per cycle, and the packet keeps the
// first hit it meets; the answer is read at the end of the row.
// req.ready is high only in the idle state. An insert passes through the hold
// state; a query passes through the scan, which spans the cell row, and then
// the hold state. The block returns to idle once the result has moved to the
// output register, so a query occupies the block for the whole scan.
// A result waits in the output register while rsp.ready is low; the block
// still takes the next item and parks its result until the output frees up.
// Reset empties the table by clearing the fill count; entry storage itself is
// not cleared, and there is no clearing pass.
// Depends on tiop_pkg, tiop_req_if, tiop_rsp_if and tiop_chain.
module typed_interval_overlap_search_unit
    import tiop_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic   clk,
    input  logic   rst_n,
    tiop_req_if.sink   req,
    tiop_rsp_if.source rsp
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_HOLD = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic             out_valid_reg, out_valid_next;
    query_t           query_reg, query_next;
    result_t          res_reg, res_next;
    result_t          out_reg, out_next;
    entry_wr_t        wr;
    packet_t          pkt_tail;
    logic [IDX_W-1:0] idx_tail;
    logic             accept;
    logic             full;
    logic [COORD_W-1:0] stored_len;
    logic [SUM_W-1:0]   neg_len;

    assign accept = req.valid && req.ready;
    assign full   = count_reg == CNT_W'(TABLE_DEPTH);

    // Deletions store end minus begin, clipped at zero; other types store the
    // magnitude of the length column, with the most negative value clipped.
    always_comb
    begin
        neg_len = 32'(-req.length_value);
        if (req.track_type == KIND_DEL)
        begin
            stored_len = (req.track_end >= req.track_begin) ?
                         (req.track_end - req.track_begin) : '0;
        end
        else if (req.length_value[31])
        begin
            stored_len = neg_len[31] ? {COORD_W{1'b1}} : neg_len[COORD_W-1:0];
        end
        else
        begin
            stored_len = req.length_value[COORD_W-1:0];
        end
        wr.en        = accept && (req.opcode == OP_INSERT) && !full;
        wr.chrom     = req.chrom_id;
        wr.begin_pos = req.track_begin;
        wr.length    = stored_len;
        wr.kind      = req.track_type;
    end

    tiop_chain #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_chain (
        .clk      (clk),
        .query    (query_reg),
        .count    (count_reg),
        .wr       (wr),
        .pkt_tail (pkt_tail),
        .idx_tail (idx_tail)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_cnt_next  = scan_cnt_reg;
        out_valid_next = out_valid_reg;
        query_next     = query_reg;
        res_next       = res_reg;
        out_next       = out_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next = '0;
                    if (req.opcode == OP_INSERT)
                    begin
                        if (full)
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            res_next.status      = ST_INSERTED;
                            res_next.entry_index = ENTRY_INDEX_W'(count_reg);
                            count_next           = count_reg + CNT_W'(1);
                        end
                        state_next = S_HOLD;
                    end
                    else
                    begin
                        query_next.chrom = req.chrom_id;
                        query_next.pos   = req.query_position;
                        query_next.qend  = {1'b0, req.query_position} +
                                           {1'b0, req.query_length};
                        scan_cnt_next    = '0;
                        state_next       = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // The packet that entered the row just after the query was
                // loaded has left the last cell when the scan count reaches TABLE_DEPTH.
                if (scan_cnt_reg == CNT_W'(TABLE_DEPTH))
                begin
                    res_next = '0;
                    if (pkt_tail.found)
                    begin
                        res_next.status      = ST_HIT;
                        res_next.entry_index = ENTRY_INDEX_W'(idx_tail);
                        res_next.hit_begin   = pkt_tail.begin_pos;
                        res_next.hit_length  = pkt_tail.length;
                        res_next.hit_type    = pkt_tail.kind;
                    end
                    else
                    begin
                        res_next.status = ST_MISS;
                    end
                    state_next = S_HOLD;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
            end
            S_HOLD:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_cnt_reg  <= scan_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        query_reg <= query_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    assign req.ready       = state_reg == S_IDLE;
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_reg.status;
    assign rsp.entry_index = out_reg.entry_index;
    assign rsp.hit_begin   = out_reg.hit_begin;
    assign rsp.hit_length  = out_reg.hit_length;
    assign rsp.hit_type    = out_reg.hit_type;

endmodule

FILE: src/tiop_checker.sv
// Port-level checks for the typed interval overlap search unit, bound to the
// top level. Depends on tiop_pkg and the top level's interface ports.
module tiop_checker
    import tiop_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [STATUS_W-1:0]      status,
    input logic [ENTRY_INDEX_W-1:0] entry_index,
    input logic [COORD_W-1:0]       hit_begin,
    input logic [COORD_W-1:0]       hit_length,
    input logic [KIND_W-1:0]        hit_type
);

    logic [1:0] pending_reg, pending_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Items accepted whose result item has not been taken yet.
    always_comb
    begin
        pending_next = pending_reg + 2'(in_acc) - 2'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_index))
        else $error("result item changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("second item taken while one is in work");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc |-> pending_reg != 2'd0) && pending_reg != 2'd3)
        else $error("result items do not match accepted items");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_HIT |->
            hit_begin == '0 && hit_length == '0 && hit_type == '0 &&
            (status == ST_INSERTED || entry_index == '0))
        else $error("non-hit result carries entry fields");

endmodule

bind typed_interval_overlap_search_unit tiop_checker u_tiop_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .status      (rsp.status),
    .entry_index (rsp.entry_index),
    .hit_begin   (rsp.hit_begin),
    .hit_length  (rsp.hit_length),
    .hit_type    (rsp.hit_type)
);

FILE: test/typed_interval_overlap_search_unit_tb.sv
// Testbench for the typed interval overlap search unit: inserts and queries with random
// idling on both channels, checked against a table predictor kept in a scoreboard class.
// Depends on tiop_pkg, tiop_req_if, tiop_rsp_if and the unit itself.
module typed_interval_overlap_search_unit_tb;
    import tiop_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SIZE = 1024;
    localparam int RANDOM_ITEMS = 520;
    localparam logic [30:0] COORD_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  chrom;
        logic [30:0] track_begin;
        logic [30:0] track_end;
        logic [1:0]  track_type;
        logic [31:0] length_value;
        logic [30:0] query_position;
        logic [30:0] query_length;
    } req_item_t;

    // Keeps a copy of the interval table and the answers the unit owes.
    class interval_table_tracker;
        logic [7:0]  chrom_of  [TABLE_SIZE];
        logic [30:0] begin_of  [TABLE_SIZE];
        logic [30:0] length_of [TABLE_SIZE];
        logic [1:0]  kind_of   [TABLE_SIZE];
        int unsigned fill;
        result_t     answers_due[$];
        int          mismatches;
        int          checked;
        int          inserts;
        int          refused;
        int          queries;
        int          hits;

        function new();
            fill = 0;
            mismatches = 0;
            checked = 0;
            inserts = 0;
            refused = 0;
            queries = 0;
            hits = 0;
        endfunction

        function logic [30:0] kept_length(logic [1:0] kind, logic [30:0] b, logic [30:0] e,
                                          logic [31:0] lv);
            logic [31:0] mag;
            if (kind == KIND_DEL)
                return (e >= b) ? e - b : 31'd0;
            mag = lv[31] ? 32'd0 - lv : lv;
            return (mag > 32'h7FFF_FFFF) ? COORD_MAX : mag[30:0];
        endfunction

        // Sums are taken at 33 bits so that nothing wraps.
        function bit covers(int unsigned idx, logic [30:0] pos, logic [30:0] qlen);
            logic [32:0] top;
            logic [32:0] reach;
            logic [32:0] start;
            start = {2'b00, begin_of[idx]};
            top   = start + {2'b00, length_of[idx]};
            reach = {2'b00, pos} + {2'b00, qlen};
            case (kind_of[idx]) inside
                KIND_INS, KIND_INV: return ({2'b00, pos} <= top) && (reach >= start);
                KIND_DEL:           return (pos <= begin_of[idx]) && (reach > start);
                default:            return 1'b0;
            endcase
        endfunction

        function void note_item(req_item_t it);
            result_t r;
            int unsigned i;
            bit found;
            r = '0;
            found = 1'b0;
            if (it.opcode == OP_INSERT)
            begin
                inserts++;
                if (fill >= TABLE_SIZE)
                begin
                    r.status = ST_FULL;
                    refused++;
                end
                else
                begin
                    chrom_of[fill]  = it.chrom;
                    begin_of[fill]  = it.track_begin;
                    length_of[fill] = kept_length(it.track_type, it.track_begin,
                                                  it.track_end, it.length_value);
                    kind_of[fill]   = it.track_type;
                    r.status = ST_INSERTED;
                    r.entry_index = 10'(fill);
                    fill++;
                end
            end
            else
            begin
                queries++;
                for (i = 0; i < fill && !found; i++)
                begin
                    if (chrom_of[i] == it.chrom &&
                        covers(i, it.query_position, it.query_length))
                    begin
                        found = 1'b1;
                        r.status = ST_HIT;
                        r.entry_index = 10'(i);
                        r.hit_begin = begin_of[i];
                        r.hit_length = length_of[i];
                        r.hit_type = kind_of[i];
                    end
                end
                if (found)
                    hits++;
                else
                    r.status = ST_MISS;
            end
            answers_due = {answers_due, r};
        endfunction

        function void check_answer(result_t got);
            result_t want;
            bit bad;
            checked++;
            if (answers_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: status %0d index %0d begin %0d",
                             got.status, got.entry_index, got.hit_begin);
                return;
            end
            want = answers_due.pop_front();
            bad = (got.status !== want.status) || (got.entry_index !== want.entry_index) ||
                  (got.hit_begin !== want.hit_begin) || (got.hit_length !== want.hit_length) ||
                  (got.hit_type !== want.hit_type);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("result %0d mismatch:", checked);
                    $display("  expected status %0d index %0d begin %0d length %0d type %0d",
                             want.status, want.entry_index, want.hit_begin,
                             want.hit_length, want.hit_type);
                    $display("  got      status %0d index %0d begin %0d length %0d type %0d",
                             got.status, got.entry_index, got.hit_begin,
                             got.hit_length, got.hit_type);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    tiop_req_if req_ch ();
    tiop_rsp_if rsp_ch ();

    typed_interval_overlap_search_unit #(
        .TABLE_DEPTH(TABLE_SIZE)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    interval_table_tracker tracker = new();

    bit sender_steady = 1'b0;
    bit rsp_steady = 1'b0;
    int rsp_hold_request = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int pick_gap(bit steady);
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [30:0] clamp31(longint v);
        if (v < 0)
            return 31'd0;
        if (v > longint'(COORD_MAX))
            return COORD_MAX;
        return 31'(v);
    endfunction

    function automatic logic [30:0] pick_coord();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 31'($urandom_range(0, 5000));
        if (r < 85)
            return 31'($urandom);
        return COORD_MAX - 31'($urandom_range(0, 50));
    endfunction

    // Mostly a few chromosomes, so that entries and queries meet often.
    function automatic logic [7:0] pick_chrom();
        if ($urandom_range(0, 99) < 85)
            return 8'($urandom_range(0, 3));
        return 8'($urandom);
    endfunction

    function automatic req_item_t noise_item();
        req_item_t it;
        it.opcode         = 1'($urandom_range(0, 1));
        it.chrom          = 8'($urandom);
        it.track_begin    = 31'($urandom);
        it.track_end      = 31'($urandom);
        it.track_type     = 2'($urandom_range(0, 3));
        it.length_value   = $urandom;
        it.query_position = 31'($urandom);
        it.query_length   = 31'($urandom);
        return it;
    endfunction

    function automatic req_item_t make_insert(logic [7:0] chrom, logic [1:0] kind,
                                              logic [30:0] b, logic [30:0] e,
                                              logic [31:0] lv);
        req_item_t it;
        it = noise_item();
        it.opcode = OP_INSERT;
        it.chrom = chrom;
        it.track_type = kind;
        it.track_begin = b;
        it.track_end = e;
        it.length_value = lv;
        return it;
    endfunction

    function automatic req_item_t make_query(logic [7:0] chrom, logic [30:0] pos,
                                             logic [30:0] qlen);
        req_item_t it;
        it = noise_item();
        it.opcode = OP_QUERY;
        it.chrom = chrom;
        it.query_position = pos;
        it.query_length = qlen;
        return it;
    endfunction

    function automatic req_item_t insert_item();
        req_item_t it;
        int unsigned r;
        it = make_insert(pick_chrom(), 2'($urandom_range(0, 3)), pick_coord(), 31'd0, 32'd0);
        r = $urandom_range(0, 99);
        if (r < 70)
            it.track_end = clamp31(longint'(it.track_begin) + $urandom_range(0, 500));
        else if (r < 85)
            it.track_end = clamp31(longint'(it.track_begin) - $urandom_range(1, 500));
        else
            it.track_end = 31'($urandom);
        r = $urandom_range(0, 99);
        if (r < 60)
            it.length_value = 32'($urandom_range(0, 1000) - 500);
        else if (r < 85)
            it.length_value = $urandom;
        else if (r < 92)
            it.length_value = 32'h8000_0000;
        else if (r < 96)
            it.length_value = 32'h7FFF_FFFF;
        else
            it.length_value = 32'd0;
        return it;
    endfunction

    // Most queries aim at a stored entry: near its edges, inside it, or at random points on its chromosome.
    function automatic req_item_t query_item();
        req_item_t it;
        int unsigned idx;
        longint b;
        longint l;
        longint d;
        longint delta;
        it = make_query(pick_chrom(), pick_coord(), pick_coord());
        if (tracker.fill == 0 || $urandom_range(0, 99) >= 75)
            return it;
        idx = $urandom_range(0, tracker.fill - 1);
        it.chrom = tracker.chrom_of[idx];
        b = longint'(tracker.begin_of[idx]);
        l = longint'(tracker.length_of[idx]);
        delta = longint'($urandom_range(0, 2)) - 1;
        case ($urandom_range(0, 3))
            0:
            begin
                d = $urandom_range(0, 300);
                it.query_position = clamp31(b - d);
                it.query_length = clamp31(b - longint'(it.query_position) + delta);
            end
            1:
            begin
                it.query_position = clamp31(b + l + delta);
                it.query_length = 31'($urandom_range(0, 300));
            end
            2:
            begin
                it.query_position = clamp31(b + longint'($urandom_range(0, 31'(l))));
                it.query_length = 31'($urandom_range(0, 300));
            end
            default:
            begin
                it.query_position = pick_coord();
                it.query_length = pick_coord();
            end
        endcase
        return it;
    endfunction

    // Called at a rising edge; returns at the edge where the item is accepted.
    task automatic send_item(input req_item_t it);
        int gap;
        gap = pick_gap(sender_steady);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.opcode         <= it.opcode;
        req_ch.chrom_id       <= it.chrom;
        req_ch.track_begin    <= it.track_begin;
        req_ch.track_end      <= it.track_end;
        req_ch.track_type     <= it.track_type;
        req_ch.length_value   <= it.length_value;
        req_ch.query_position <= it.query_position;
        req_ch.query_length   <= it.query_length;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        tracker.note_item(it);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (tracker.answers_due.size() != 0);
    endtask

    // Result side: checks each accepted item and decides ready for the next cycle.
    initial
    begin
        int stall_left;
        int unsigned r;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
                tracker.check_answer({rsp_ch.status, rsp_ch.entry_index, rsp_ch.hit_begin,
                                      rsp_ch.hit_length, rsp_ch.hit_type});
            if (rsp_hold_request > 0)
            begin
                stall_left = rsp_hold_request;
                rsp_hold_request = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (rsp_steady)
            begin
                rsp_ch.ready <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    rsp_ch.ready <= 1'b1;
                end
                else
                begin
                    stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(15, 60);
                    rsp_ch.ready <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d result items outstanding", tracker.answers_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int k;
        rst_n                 = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.opcode         = OP_INSERT;
        req_ch.chrom_id       = '0;
        req_ch.track_begin    = '0;
        req_ch.track_end      = '0;
        req_ch.track_type     = KIND_DEL;
        req_ch.length_value   = '0;
        req_ch.query_position = '0;
        req_ch.query_length   = '0;
        rsp_ch.ready          = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty table, saturations, wide sums and the edges of each type.
        send_item(make_query(8'd0, 31'd0, 31'd0));
        send_item(make_insert(8'd0, KIND_DEL, 31'd100, 31'd150, 32'd0));
        send_item(make_insert(8'd0, KIND_DEL, 31'd300, 31'd200, 32'd0));
        send_item(make_insert(8'd1, KIND_INS, 31'd1000, 31'd0, 32'h8000_0000));
        send_item(make_insert(8'd2, KIND_INV, COORD_MAX, 31'd0, 32'h7FFF_FFFF));
        send_item(make_insert(8'd3, KIND_OTHER, 31'd500, 31'd0, 32'd20));
        send_item(make_insert(8'd1, KIND_INS, 31'd0, 31'd0, -32'sd5));
        send_item(make_insert(8'd4, KIND_DEL, 31'd0, COORD_MAX, 32'd0));
        send_item(make_insert(8'd255, KIND_INS, 31'd10, 31'd0, 32'd0));
        send_item(make_insert(8'd5, KIND_INV, 31'd40, 31'd0, 32'hFFFF_FFFF));
        send_item(make_query(8'd0, 31'd100, 31'd0));
        send_item(make_query(8'd0, 31'd100, 31'd1));
        send_item(make_query(8'd0, 31'd101, 31'd1000));
        send_item(make_query(8'd1, COORD_MAX, COORD_MAX));
        send_item(make_query(8'd2, COORD_MAX, 31'd0));
        send_item(make_query(8'd3, 31'd500, 31'd100));
        send_item(make_query(8'd1, 31'd0, 31'd0));
        send_item(make_query(8'd255, 31'd10, 31'd0));
        send_item(make_query(8'd255, 31'd11, 31'd0));
        send_item(make_query(8'd4, 31'd0, 31'd0));
        send_item(make_query(8'd7, 31'd0, COORD_MAX));
        send_item(make_query(8'd5, 31'd41, 31'd0));
        send_item(make_query(8'd5, 31'd42, 31'd0));
        send_item(make_query(8'd5, 31'd30, 31'd9));
        send_item(make_query(8'd5, 31'd30, 31'd10));
        wait_drained();

        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == 150)
            begin
                // Let everything drain, then block the result side while inserts pile up.
                wait_drained();
                sender_steady = 1'b1;
                rsp_hold_request = 400;
                repeat (12) send_item(insert_item());
                sender_steady = 1'b0;
            end
            if (k == 250)
            begin
                sender_steady = 1'b1;
                rsp_steady = 1'b1;
            end
            if (k == 310)
            begin
                sender_steady = 1'b0;
                rsp_steady = 1'b0;
            end
            if ($urandom_range(0, 1) == 0)
                send_item(insert_item());
            else
                send_item(query_item());
        end

        // A fresh entry that a query finds right away, then a short mixed tail.
        send_item(make_insert(8'd250, KIND_INS, 31'd77, 31'd0, 32'd3));
        send_item(make_query(8'd250, 31'd78, 31'd0));
        send_item(make_insert(8'd255, KIND_OTHER, COORD_MAX, COORD_MAX, 32'h8000_0000));
        for (k = 0; k < 20; k++)
        begin
            if (k % 2 == 0)
                send_item(insert_item());
            else
                send_item(query_item());
        end

        wait_drained();
        repeat (TABLE_SIZE + 8) @(posedge clk);
        if (tracker.answers_due.size() != 0)
            tracker.mismatches++;

        $display("Sent %0d inserts (%0d refused on a full table) and %0d queries (%0d hits).",
                 tracker.inserts, tracker.refused, tracker.queries, tracker.hits);
        $display("Checked %0d result items, %0d mismatches.", tracker.checked,
                 tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
